/* rtl/sensor_record_statistics_top_assert.svh */
// Assertion macros shared by the sensor record statistics RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef SENSOR_RECORD_STATISTICS_TOP_ASSERT_SVH
`define SENSOR_RECORD_STATISTICS_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("srs: assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("srs: assertion failed");

`endif

/* rtl/srs_pkg.sv */
// Package for the sensor record statistics block: widths, codes, reset values, types.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package srs_pkg;

    // spreading factor set size per site
    localparam int SF_SLOTS  = 10;
    localparam int SF_USED_W = $clog2(SF_SLOTS + 1);

    // field widths
    localparam int MASK_W   = 5;
    localparam int TEMP_W   = 15;
    localparam int HUM_W    = 14;
    localparam int PRESS_W  = 18;
    localparam int BAT_W    = 16;
    localparam int TS_W     = 64;
    localparam int SF_W     = 4;
    localparam int IDX_W    = 6;
    localparam int VAL_W    = 64;

    // statistic widths
    localparam int HUMX_W   = 15;
    localparam int PRESSX_W = 19;
    localparam int TSUM_W   = 48;
    localparam int HSUM_W   = 48;
    localparam int PSUM_W   = 56;
    localparam int CNT_W    = 32;

    // commands
    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // presence bits
    localparam int PM_TEMP  = 0;
    localparam int PM_HUM   = 1;
    localparam int PM_PRESS = 2;
    localparam int PM_BAT   = 3;
    localparam int PM_SF    = 4;

    // extreme timestamp slots
    localparam int EXT_TEMP_MIN  = 0;
    localparam int EXT_TEMP_MAX  = 1;
    localparam int EXT_HUM_MIN   = 2;
    localparam int EXT_HUM_MAX   = 3;
    localparam int EXT_PRESS_MIN = 4;
    localparam int EXT_PRESS_MAX = 5;
    localparam int EXT_N         = 6;

    // reset values of the extremes
    localparam logic signed [TEMP_W-1:0]   TEMP_MIN_RST  = 15'sd10000;
    localparam logic signed [TEMP_W-1:0]   TEMP_MAX_RST  = -15'sd10000;
    localparam logic signed [HUMX_W-1:0]   HUM_MIN_RST   = 15'sd10100;
    localparam logic signed [HUMX_W-1:0]   HUM_MAX_RST   = -15'sd100;
    localparam logic signed [PRESSX_W-1:0] PRESS_MIN_RST = 19'sd200000;
    localparam logic signed [PRESSX_W-1:0] PRESS_MAX_RST = -19'sd100;

    typedef logic [IDX_W-1:0]     t_stat_idx;
    typedef logic [SF_USED_W-1:0] t_sf_used;

    // read index map
    localparam t_stat_idx STAT_TEMP_MIN     = 6'd0;
    localparam t_stat_idx STAT_TEMP_MAX     = 6'd1;
    localparam t_stat_idx STAT_TEMP_SUM     = 6'd2;
    localparam t_stat_idx STAT_HUM_MIN      = 6'd3;
    localparam t_stat_idx STAT_HUM_MAX      = 6'd4;
    localparam t_stat_idx STAT_HUM_SUM      = 6'd5;
    localparam t_stat_idx STAT_PRESS_MIN    = 6'd6;
    localparam t_stat_idx STAT_PRESS_MAX    = 6'd7;
    localparam t_stat_idx STAT_PRESS_SUM    = 6'd8;
    localparam t_stat_idx STAT_TS_TEMP_MIN  = 6'd9;
    localparam t_stat_idx STAT_TS_TEMP_MAX  = 6'd10;
    localparam t_stat_idx STAT_TS_HUM_MIN   = 6'd11;
    localparam t_stat_idx STAT_TS_HUM_MAX   = 6'd12;
    localparam t_stat_idx STAT_TS_PRESS_MIN = 6'd13;
    localparam t_stat_idx STAT_TS_PRESS_MAX = 6'd14;
    localparam t_stat_idx STAT_BAT_FIRST    = 6'd15;
    localparam t_stat_idx STAT_BAT_LAST     = 6'd16;
    localparam t_stat_idx STAT_BAT_FIRST_TS = 6'd17;
    localparam t_stat_idx STAT_BAT_LAST_TS  = 6'd18;
    localparam t_stat_idx STAT_REC_COUNT    = 6'd19;
    localparam t_stat_idx STAT_MISS_TEMP    = 6'd20;
    localparam t_stat_idx STAT_MISS_HUM     = 6'd21;
    localparam t_stat_idx STAT_MISS_PRESS   = 6'd22;
    localparam t_stat_idx STAT_SF_USED      = 6'd23;
    localparam t_stat_idx STAT_SF_BASE      = 6'd24;

    // record payload
    typedef struct packed {
        logic [MASK_W-1:0]         present_mask;
        logic signed [TEMP_W-1:0]  temperature;
        logic [HUM_W-1:0]          humidity;
        logic [PRESS_W-1:0]        pressure;
        logic [BAT_W-1:0]          battery;
        logic [TS_W-1:0]           timestamp;
        logic [SF_W-1:0]           spreading_factor;
    } t_rec;

    // one input transaction
    typedef struct packed {
        logic      command;
        logic      site;
        t_rec      rec;
        t_stat_idx stat_index;
    } t_item;

    // read response
    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic             index_error;
    } t_read_rsp;

endpackage

`default_nettype wire

/* rtl/srs_if.sv */
// Valid/ready channel interfaces for the sensor record statistics block.
// Depends on srs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface srs_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 command;
    logic                                 site;
    logic [srs_pkg::MASK_W-1:0]           present_mask;
    logic signed [srs_pkg::TEMP_W-1:0]    temperature;
    logic [srs_pkg::HUM_W-1:0]            humidity;
    logic [srs_pkg::PRESS_W-1:0]          pressure;
    logic [srs_pkg::BAT_W-1:0]            battery;
    logic [srs_pkg::TS_W-1:0]             timestamp;
    logic [srs_pkg::SF_W-1:0]             spreading_factor;
    logic [srs_pkg::IDX_W-1:0]            stat_index;

    modport source (
        output valid, command, site, present_mask, temperature, humidity, pressure,
               battery, timestamp, spreading_factor, stat_index,
        input  ready
    );
    modport sink (
        input  valid, command, site, present_mask, temperature, humidity, pressure,
               battery, timestamp, spreading_factor, stat_index,
        output ready
    );
endinterface

interface srs_out_if;
    logic                        valid;
    logic                        ready;
    logic [srs_pkg::VAL_W-1:0]   read_value;
    logic                        index_error;

    modport source (output valid, read_value, index_error, input ready);
    modport sink   (input valid, read_value, index_error, output ready);
endinterface

`default_nettype wire

/* rtl/srs_site_stats.sv */
// Statistics registers of one site: record update logic and read selection.
// Depends on srs_pkg and sensor_record_statistics_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "sensor_record_statistics_top_assert.svh"

module srs_site_stats (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_upd,
    input  srs_pkg::t_rec      i_rec,
    input  srs_pkg::t_stat_idx i_stat_index,
    output srs_pkg::t_read_rsp o_rsp
);

    logic signed [srs_pkg::TEMP_W-1:0]   r_temp_min, r_temp_max, n_temp_min, n_temp_max;
    logic signed [srs_pkg::HUMX_W-1:0]   r_hum_min, r_hum_max, n_hum_min, n_hum_max;
    logic signed [srs_pkg::PRESSX_W-1:0] r_press_min, r_press_max, n_press_min, n_press_max;
    logic [srs_pkg::TSUM_W-1:0]          r_temp_sum, n_temp_sum;
    logic [srs_pkg::HSUM_W-1:0]          r_hum_sum, n_hum_sum;
    logic [srs_pkg::PSUM_W-1:0]          r_press_sum, n_press_sum;
    logic [srs_pkg::TS_W-1:0]            r_stamp [srs_pkg::EXT_N];
    logic [srs_pkg::TS_W-1:0]            n_stamp [srs_pkg::EXT_N];
    logic [srs_pkg::BAT_W-1:0]           r_bat_first, r_bat_last, n_bat_first, n_bat_last;
    logic [srs_pkg::TS_W-1:0]            r_bat_first_ts, r_bat_last_ts;
    logic [srs_pkg::TS_W-1:0]            n_bat_first_ts, n_bat_last_ts;
    logic                                r_bat_pending, n_bat_pending;
    logic [srs_pkg::CNT_W-1:0]           r_rec_count, n_rec_count;
    logic [srs_pkg::CNT_W-1:0]           r_miss_temp, r_miss_hum, r_miss_press;
    logic [srs_pkg::CNT_W-1:0]           n_miss_temp, n_miss_hum, n_miss_press;
    srs_pkg::t_sf_used                   r_sf_used, n_sf_used;
    logic [srs_pkg::SF_W-1:0]            r_sf_slot [srs_pkg::SF_SLOTS];
    logic [srs_pkg::SF_W-1:0]            n_sf_slot [srs_pkg::SF_SLOTS];

    logic signed [srs_pkg::HUMX_W-1:0]   hum_x;
    logic signed [srs_pkg::PRESSX_W-1:0] press_x;
    logic                                sf_seen;
    srs_pkg::t_stat_idx                  sf_rel;

    // record update
    always_comb begin
        n_temp_min     = r_temp_min;
        n_temp_max     = r_temp_max;
        n_hum_min      = r_hum_min;
        n_hum_max      = r_hum_max;
        n_press_min    = r_press_min;
        n_press_max    = r_press_max;
        n_temp_sum     = r_temp_sum;
        n_hum_sum      = r_hum_sum;
        n_press_sum    = r_press_sum;
        n_stamp        = r_stamp;
        n_bat_first    = r_bat_first;
        n_bat_last     = r_bat_last;
        n_bat_first_ts = r_bat_first_ts;
        n_bat_last_ts  = r_bat_last_ts;
        n_bat_pending  = r_bat_pending;
        n_rec_count    = r_rec_count;
        n_miss_temp    = r_miss_temp;
        n_miss_hum     = r_miss_hum;
        n_miss_press   = r_miss_press;
        n_sf_used      = r_sf_used;
        n_sf_slot      = r_sf_slot;

        hum_x   = $signed({1'b0, i_rec.humidity});
        press_x = $signed({1'b0, i_rec.pressure});

        // parallel match against the filled slots
        sf_seen = 1'b0;
        for (int k = 0; k < srs_pkg::SF_SLOTS; k++) begin
            if (srs_pkg::t_sf_used'(k) < r_sf_used &&
                r_sf_slot[k] == i_rec.spreading_factor) begin
                sf_seen = 1'b1;
            end
        end

        if (i_upd) begin
            n_rec_count = r_rec_count + 1'b1;

            if (i_rec.present_mask[srs_pkg::PM_TEMP]) begin
                if (i_rec.temperature < r_temp_min) begin
                    n_temp_min = i_rec.temperature;
                    n_stamp[srs_pkg::EXT_TEMP_MIN] = i_rec.timestamp;
                end
                if (i_rec.temperature > r_temp_max) begin
                    n_temp_max = i_rec.temperature;
                    n_stamp[srs_pkg::EXT_TEMP_MAX] = i_rec.timestamp;
                end
                n_temp_sum = r_temp_sum + srs_pkg::TSUM_W'(i_rec.temperature);
            end else begin
                n_miss_temp = r_miss_temp + 1'b1;
            end

            if (i_rec.present_mask[srs_pkg::PM_HUM]) begin
                if (hum_x < r_hum_min) begin
                    n_hum_min = hum_x;
                    n_stamp[srs_pkg::EXT_HUM_MIN] = i_rec.timestamp;
                end
                if (hum_x > r_hum_max) begin
                    n_hum_max = hum_x;
                    n_stamp[srs_pkg::EXT_HUM_MAX] = i_rec.timestamp;
                end
                n_hum_sum = r_hum_sum + srs_pkg::HSUM_W'(i_rec.humidity);
            end else begin
                n_miss_hum = r_miss_hum + 1'b1;
            end

            if (i_rec.present_mask[srs_pkg::PM_PRESS]) begin
                if (press_x < r_press_min) begin
                    n_press_min = press_x;
                    n_stamp[srs_pkg::EXT_PRESS_MIN] = i_rec.timestamp;
                end
                if (press_x > r_press_max) begin
                    n_press_max = press_x;
                    n_stamp[srs_pkg::EXT_PRESS_MAX] = i_rec.timestamp;
                end
                n_press_sum = r_press_sum + srs_pkg::PSUM_W'(i_rec.pressure);
            end else begin
                n_miss_press = r_miss_press + 1'b1;
            end

            if (i_rec.present_mask[srs_pkg::PM_BAT]) begin
                if (r_bat_pending || i_rec.timestamp < r_bat_first_ts) begin
                    n_bat_first    = i_rec.battery;
                    n_bat_first_ts = i_rec.timestamp;
                    n_bat_pending  = 1'b0;
                end
                // a zero latest stamp means none seen yet
                if (r_bat_last_ts == '0 || i_rec.timestamp > r_bat_last_ts) begin
                    n_bat_last    = i_rec.battery;
                    n_bat_last_ts = i_rec.timestamp;
                end
            end

            if (i_rec.present_mask[srs_pkg::PM_SF] && !sf_seen &&
                r_sf_used < srs_pkg::t_sf_used'(srs_pkg::SF_SLOTS)) begin
                for (int k = 0; k < srs_pkg::SF_SLOTS; k++) begin
                    if (srs_pkg::t_sf_used'(k) == r_sf_used) begin
                        n_sf_slot[k] = i_rec.spreading_factor;
                    end
                end
                n_sf_used = r_sf_used + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_min     <= srs_pkg::TEMP_MIN_RST;
            r_temp_max     <= srs_pkg::TEMP_MAX_RST;
            r_hum_min      <= srs_pkg::HUM_MIN_RST;
            r_hum_max      <= srs_pkg::HUM_MAX_RST;
            r_press_min    <= srs_pkg::PRESS_MIN_RST;
            r_press_max    <= srs_pkg::PRESS_MAX_RST;
            r_temp_sum     <= '0;
            r_hum_sum      <= '0;
            r_press_sum    <= '0;
            for (int k = 0; k < srs_pkg::EXT_N; k++) begin
                r_stamp[k] <= '0;
            end
            r_bat_first    <= '0;
            r_bat_last     <= '0;
            r_bat_first_ts <= '0;
            r_bat_last_ts  <= '0;
            r_bat_pending  <= 1'b1;
            r_rec_count    <= '0;
            r_miss_temp    <= '0;
            r_miss_hum     <= '0;
            r_miss_press   <= '0;
            r_sf_used      <= '0;
        end else begin
            r_temp_min     <= n_temp_min;
            r_temp_max     <= n_temp_max;
            r_hum_min      <= n_hum_min;
            r_hum_max      <= n_hum_max;
            r_press_min    <= n_press_min;
            r_press_max    <= n_press_max;
            r_temp_sum     <= n_temp_sum;
            r_hum_sum      <= n_hum_sum;
            r_press_sum    <= n_press_sum;
            r_stamp        <= n_stamp;
            r_bat_first    <= n_bat_first;
            r_bat_last     <= n_bat_last;
            r_bat_first_ts <= n_bat_first_ts;
            r_bat_last_ts  <= n_bat_last_ts;
            r_bat_pending  <= n_bat_pending;
            r_rec_count    <= n_rec_count;
            r_miss_temp    <= n_miss_temp;
            r_miss_hum     <= n_miss_hum;
            r_miss_press   <= n_miss_press;
            r_sf_used      <= n_sf_used;
        end
    end

    // slots are only read below the fill count, so no reset
    always_ff @(posedge i_clk) begin
        r_sf_slot <= n_sf_slot;
    end

    // read selection
    always_comb begin
        o_rsp.read_value  = '0;
        o_rsp.index_error = 1'b0;
        sf_rel            = i_stat_index - srs_pkg::STAT_SF_BASE;
        case (i_stat_index)
            srs_pkg::STAT_TEMP_MIN:     o_rsp.read_value = srs_pkg::VAL_W'(r_temp_min);
            srs_pkg::STAT_TEMP_MAX:     o_rsp.read_value = srs_pkg::VAL_W'(r_temp_max);
            srs_pkg::STAT_TEMP_SUM:     o_rsp.read_value = srs_pkg::VAL_W'($signed(r_temp_sum));
            srs_pkg::STAT_HUM_MIN:      o_rsp.read_value = srs_pkg::VAL_W'(r_hum_min);
            srs_pkg::STAT_HUM_MAX:      o_rsp.read_value = srs_pkg::VAL_W'(r_hum_max);
            srs_pkg::STAT_HUM_SUM:      o_rsp.read_value = srs_pkg::VAL_W'(r_hum_sum);
            srs_pkg::STAT_PRESS_MIN:    o_rsp.read_value = srs_pkg::VAL_W'(r_press_min);
            srs_pkg::STAT_PRESS_MAX:    o_rsp.read_value = srs_pkg::VAL_W'(r_press_max);
            srs_pkg::STAT_PRESS_SUM:    o_rsp.read_value = srs_pkg::VAL_W'(r_press_sum);
            srs_pkg::STAT_TS_TEMP_MIN:  o_rsp.read_value = r_stamp[srs_pkg::EXT_TEMP_MIN];
            srs_pkg::STAT_TS_TEMP_MAX:  o_rsp.read_value = r_stamp[srs_pkg::EXT_TEMP_MAX];
            srs_pkg::STAT_TS_HUM_MIN:   o_rsp.read_value = r_stamp[srs_pkg::EXT_HUM_MIN];
            srs_pkg::STAT_TS_HUM_MAX:   o_rsp.read_value = r_stamp[srs_pkg::EXT_HUM_MAX];
            srs_pkg::STAT_TS_PRESS_MIN: o_rsp.read_value = r_stamp[srs_pkg::EXT_PRESS_MIN];
            srs_pkg::STAT_TS_PRESS_MAX: o_rsp.read_value = r_stamp[srs_pkg::EXT_PRESS_MAX];
            srs_pkg::STAT_BAT_FIRST:    o_rsp.read_value = srs_pkg::VAL_W'(r_bat_first);
            srs_pkg::STAT_BAT_LAST:     o_rsp.read_value = srs_pkg::VAL_W'(r_bat_last);
            srs_pkg::STAT_BAT_FIRST_TS: o_rsp.read_value = r_bat_first_ts;
            srs_pkg::STAT_BAT_LAST_TS:  o_rsp.read_value = r_bat_last_ts;
            srs_pkg::STAT_REC_COUNT:    o_rsp.read_value = srs_pkg::VAL_W'(r_rec_count);
            srs_pkg::STAT_MISS_TEMP:    o_rsp.read_value = srs_pkg::VAL_W'(r_miss_temp);
            srs_pkg::STAT_MISS_HUM:     o_rsp.read_value = srs_pkg::VAL_W'(r_miss_hum);
            srs_pkg::STAT_MISS_PRESS:   o_rsp.read_value = srs_pkg::VAL_W'(r_miss_press);
            srs_pkg::STAT_SF_USED:      o_rsp.read_value = srs_pkg::VAL_W'(r_sf_used);
            default: begin
                // slot reads are valid only below the fill count
                if (i_stat_index >= srs_pkg::STAT_SF_BASE &&
                    sf_rel < srs_pkg::t_stat_idx'(r_sf_used)) begin
                    for (int k = 0; k < srs_pkg::SF_SLOTS; k++) begin
                        if (sf_rel == srs_pkg::t_stat_idx'(k)) begin
                            o_rsp.read_value = srs_pkg::VAL_W'(r_sf_slot[k]);
                        end
                    end
                end else begin
                    o_rsp.index_error = 1'b1;
                end
            end
        endcase
    end

    `SRS_ASSERT_NOW(a_sf_used_bound, i_clk, i_rst_n, 1'b1,
        r_sf_used <= srs_pkg::t_sf_used'(srs_pkg::SF_SLOTS))
    `SRS_ASSERT_NEXT(a_bat_pending_clears, i_clk, i_rst_n,
        i_upd && i_rec.present_mask[srs_pkg::PM_BAT], !r_bat_pending)
    `SRS_ASSERT_NEXT(a_temp_min_tracks, i_clk, i_rst_n,
        i_upd && i_rec.present_mask[srs_pkg::PM_TEMP],
        r_temp_min <= $past(i_rec.temperature))

endmodule

`default_nettype wire

/* rtl/sensor_record_statistics_top.sv */
// Top level of the sensor record statistics block: input register, two site
// stat banks and the read result register. Depends on srs_pkg, srs_if,
// srs_site_stats and sensor_record_statistics_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "sensor_record_statistics_top_assert.svh"

// Keeps running statistics (strict min/max with timestamps, sums, missing
// counts, earliest/latest battery level, set of distinct spreading factors)
// for two sites. A record transaction updates the selected site and gives no
// result; a read transaction returns one statistic by index, or index_error
// with a zero value. The block takes one transaction per cycle while no read
// waits on a stalled result: each transaction is registered, then resolved in
// a single pass through the site compare/add logic as it leaves the input
// register. A read result is held in the result register until taken; a
// stalled result blocks a later read but records keep flowing behind it as
// long as the input register can drain. Reads see every earlier record.

module sensor_record_statistics_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    srs_in_if.sink       i_in,
    srs_out_if.source    o_out
);

    // input register
    logic                r_s1_valid;
    srs_pkg::t_item      r_s1;
    logic                s1_adv;
    logic                out_free;

    // result register
    logic                r_out_valid;
    srs_pkg::t_read_rsp  r_out;

    // per-site update strobes and read responses
    logic                site_upd [2];
    srs_pkg::t_read_rsp  site_rsp [2];

    // Output slot is free when empty or being drained this cycle. A record
    // never needs it, so a record always leaves the input register.
    assign out_free = !r_out_valid || o_out.ready;
    assign s1_adv   = r_s1_valid && (r_s1.command == srs_pkg::CMD_RECORD || out_free);

    assign i_in.ready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1.command               <= i_in.command;
            r_s1.site                  <= i_in.site;
            r_s1.rec.present_mask      <= i_in.present_mask;
            r_s1.rec.temperature       <= i_in.temperature;
            r_s1.rec.humidity          <= i_in.humidity;
            r_s1.rec.pressure          <= i_in.pressure;
            r_s1.rec.battery           <= i_in.battery;
            r_s1.rec.timestamp         <= i_in.timestamp;
            r_s1.rec.spreading_factor  <= i_in.spreading_factor;
            r_s1.stat_index            <= i_in.stat_index;
        end
    end

    // one stat bank per site; only the addressed bank is updated by the record
    for (genvar s = 0; s < 2; s++) begin : g_site
        assign site_upd[s] = s1_adv && r_s1.command == srs_pkg::CMD_RECORD &&
                             r_s1.site == 1'(s);

        srs_site_stats u_site (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_upd        (site_upd[s]),
            .i_rec        (r_s1.rec),
            .i_stat_index (r_s1.stat_index),
            .o_rsp        (site_rsp[s])
        );
    end

    // result register: load on a read leaving stage one, clear when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1.command == srs_pkg::CMD_READ) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1.command == srs_pkg::CMD_READ) begin
            r_out <= r_s1.site ? site_rsp[1] : site_rsp[0];
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.read_value  = r_out.read_value;
    assign o_out.index_error = r_out.index_error;

    `SRS_ASSERT_NEXT(a_accept_fills_s1, i_clk, i_rst_n,
        i_in.valid && i_in.ready, r_s1_valid)
    `SRS_ASSERT_NEXT(a_read_gives_result, i_clk, i_rst_n,
        s1_adv && r_s1.command == srs_pkg::CMD_READ, r_out_valid)
    `SRS_ASSERT_NEXT(a_record_is_silent, i_clk, i_rst_n,
        r_s1_valid && r_s1.command == srs_pkg::CMD_RECORD && !r_out_valid, !r_out_valid)
    `SRS_ASSERT_NOW(a_error_reads_zero, i_clk, i_rst_n,
        r_out_valid && r_out.index_error, r_out.read_value == '0)

endmodule

`default_nettype wire

/* tb/sensor_record_statistics_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for sensor_record_statistics_top: record and read transactions
// with random idling and backpressure, reads scored against a per-site statistics predictor.
// Depends on srs_pkg, srs_if and the block's RTL.

module sensor_record_statistics_top_tb;
    import srs_pkg::*;

    localparam int N_RANDOM       = 675;  // random transactions after the directed part
    localparam int QUIET_TAIL     = 100;  // last transactions run without any idling
    localparam int LONG_HOLD      = 200;  // cycles of the long output hold
    localparam int WATCHDOG_LIMIT = 2000; // cycles without any handshake before giving up
    localparam int DRAIN_CYCLES   = 8;    // idle cycles after the last result before the report
    localparam int BAT_EARLY      = 0;
    localparam int BAT_LATE       = 1;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow copy of both sites' statistics. Records update the
    // shadow state, reads push the expected response, results pop and compare.
    // ------------------------------------------------------------------------
    class site_stats_scoreboard;
        // extremes per site, quantity 0 temperature, 1 humidity, 2 pressure
        int                 lo[2][3];
        int                 hi[2][3];
        logic [TSUM_W-1:0]  temp_acc[2];
        logic [HSUM_W-1:0]  hum_acc[2];
        logic [PSUM_W-1:0]  pres_acc[2];
        logic [TS_W-1:0]    ext_ts[2][EXT_N];
        logic [BAT_W-1:0]   bat_lvl[2][2];
        logic [TS_W-1:0]    bat_ts[2][2];
        bit                 bat_first_pending[2];
        logic [CNT_W-1:0]   rec_cnt[2];
        logic [CNT_W-1:0]   miss_cnt[2][3];
        logic [SF_W-1:0]    sf_set[2][SF_SLOTS];
        int                 sf_cnt[2];

        t_read_rsp          read_rsp_q[$];
        int                 n_fail;
        int                 n_records;
        int                 n_reads;
        int                 n_bad_index;

        function new();
            int s;
            int q;
            for (s = 0; s < 2; s++) begin
                lo[s][0] = int'(TEMP_MIN_RST);
                hi[s][0] = int'(TEMP_MAX_RST);
                lo[s][1] = int'(HUM_MIN_RST);
                hi[s][1] = int'(HUM_MAX_RST);
                lo[s][2] = int'(PRESS_MIN_RST);
                hi[s][2] = int'(PRESS_MAX_RST);
                temp_acc[s] = '0;
                hum_acc[s] = '0;
                pres_acc[s] = '0;
                for (q = 0; q < EXT_N; q++) ext_ts[s][q] = '0;
                for (q = 0; q < 2; q++) begin
                    bat_lvl[s][q] = '0;
                    bat_ts[s][q] = '0;
                end
                bat_first_pending[s] = 1'b1;
                rec_cnt[s] = '0;
                for (q = 0; q < 3; q++) miss_cnt[s][q] = '0;
                for (q = 0; q < SF_SLOTS; q++) sf_set[s][q] = '0;
                sf_cnt[s] = 0;
            end
            n_fail = 0;
            n_records = 0;
            n_reads = 0;
            n_bad_index = 0;
        endfunction

        function int pending();
            return read_rsp_q.size();
        endfunction

        function logic [VAL_W-1:0] to_word(int v);
            longint w;
            w = longint'(v);
            return w;
        endfunction

        // statistic of one site by dense index
        function t_read_rsp predict_read(bit s, t_stat_idx idx);
            t_read_rsp r;
            int k;
            r.read_value = '0;
            r.index_error = 1'b0;
            k = int'(idx);
            case (idx)
                STAT_TEMP_MIN:     r.read_value = to_word(lo[s][0]);
                STAT_TEMP_MAX:     r.read_value = to_word(hi[s][0]);
                STAT_TEMP_SUM:     r.read_value = {{(VAL_W-TSUM_W){temp_acc[s][TSUM_W-1]}},
                                                   temp_acc[s]};
                STAT_HUM_MIN:      r.read_value = to_word(lo[s][1]);
                STAT_HUM_MAX:      r.read_value = to_word(hi[s][1]);
                STAT_HUM_SUM:      r.read_value = VAL_W'(hum_acc[s]);
                STAT_PRESS_MIN:    r.read_value = to_word(lo[s][2]);
                STAT_PRESS_MAX:    r.read_value = to_word(hi[s][2]);
                STAT_PRESS_SUM:    r.read_value = VAL_W'(pres_acc[s]);
                STAT_BAT_FIRST:    r.read_value = VAL_W'(bat_lvl[s][BAT_EARLY]);
                STAT_BAT_LAST:     r.read_value = VAL_W'(bat_lvl[s][BAT_LATE]);
                STAT_BAT_FIRST_TS: r.read_value = bat_ts[s][BAT_EARLY];
                STAT_BAT_LAST_TS:  r.read_value = bat_ts[s][BAT_LATE];
                STAT_REC_COUNT:    r.read_value = VAL_W'(rec_cnt[s]);
                STAT_SF_USED:      r.read_value = VAL_W'(sf_cnt[s]);
                default: begin
                    if (k >= int'(STAT_TS_TEMP_MIN) && k <= int'(STAT_TS_PRESS_MAX)) begin
                        r.read_value = ext_ts[s][k - int'(STAT_TS_TEMP_MIN)];
                    end else if (k >= int'(STAT_MISS_TEMP) && k <= int'(STAT_MISS_PRESS)) begin
                        r.read_value = VAL_W'(miss_cnt[s][k - int'(STAT_MISS_TEMP)]);
                    end else if (k >= int'(STAT_SF_BASE) &&
                                 k - int'(STAT_SF_BASE) < sf_cnt[s]) begin
                        r.read_value = VAL_W'(sf_set[s][k - int'(STAT_SF_BASE)]);
                    end else begin
                        // out of range, or a spreading factor slot not filled yet
                        r.index_error = 1'b1;
                    end
                end
            endcase
            return r;
        endfunction

        // called for every transaction accepted at the input
        function void note_transaction(t_item it);
            int        qv[3];
            bit        s;
            int        q;
            int        k;
            bit        seen;
            logic [TS_W-1:0] ts;
            t_read_rsp r;
            s = it.site;
            if (it.command == CMD_READ) begin
                r = predict_read(s, it.stat_index);
                if (r.index_error) n_bad_index++;
                read_rsp_q.push_back(r);
                n_reads++;
                return;
            end
            n_records++;
            ts = it.rec.timestamp;
            qv[0] = int'(it.rec.temperature);
            qv[1] = int'(it.rec.humidity);
            qv[2] = int'(it.rec.pressure);
            // strict compares: an equal value keeps the old extreme and stamp
            for (q = 0; q < 3; q++) begin
                if (it.rec.present_mask[PM_TEMP + q]) begin
                    if (qv[q] < lo[s][q]) begin
                        lo[s][q] = qv[q];
                        ext_ts[s][2*q] = ts;
                    end
                    if (qv[q] > hi[s][q]) begin
                        hi[s][q] = qv[q];
                        ext_ts[s][2*q+1] = ts;
                    end
                end else begin
                    miss_cnt[s][q]++;
                end
            end
            if (it.rec.present_mask[PM_TEMP])
                temp_acc[s] = temp_acc[s] + {{(TSUM_W-TEMP_W){it.rec.temperature[TEMP_W-1]}},
                                             it.rec.temperature};
            if (it.rec.present_mask[PM_HUM])
                hum_acc[s] = hum_acc[s] + HSUM_W'(it.rec.humidity);
            if (it.rec.present_mask[PM_PRESS])
                pres_acc[s] = pres_acc[s] + PSUM_W'(it.rec.pressure);
            if (it.rec.present_mask[PM_BAT]) begin
                if (bat_first_pending[s] || ts < bat_ts[s][BAT_EARLY]) begin
                    bat_lvl[s][BAT_EARLY] = it.rec.battery;
                    bat_ts[s][BAT_EARLY] = ts;
                    bat_first_pending[s] = 1'b0;
                end
                // a stored latest stamp of zero means none yet
                if (bat_ts[s][BAT_LATE] == '0 || ts > bat_ts[s][BAT_LATE]) begin
                    bat_lvl[s][BAT_LATE] = it.rec.battery;
                    bat_ts[s][BAT_LATE] = ts;
                end
            end
            if (it.rec.present_mask[PM_SF]) begin
                seen = 1'b0;
                for (k = 0; k < sf_cnt[s]; k++)
                    if (sf_set[s][k] == it.rec.spreading_factor) seen = 1'b1;
                if (!seen && sf_cnt[s] < SF_SLOTS) begin
                    sf_set[s][sf_cnt[s]] = it.rec.spreading_factor;
                    sf_cnt[s]++;
                end
            end
            rec_cnt[s]++;
        endfunction

        // called for every result accepted at the output
        function void check_read(logic [VAL_W-1:0] value, logic err);
            t_read_rsp exp_rsp;
            if (read_rsp_q.size() == 0) begin
                $error("unexpected read result: read_value %h index_error %b", value, err);
                n_fail++;
                return;
            end
            exp_rsp = read_rsp_q.pop_front();
            if (value !== exp_rsp.read_value) begin
                $error("read_value mismatch: expected %h, actual %h",
                       exp_rsp.read_value, value);
                n_fail++;
            end
            if (err !== exp_rsp.index_error) begin
                $error("index_error mismatch: expected %b, actual %b",
                       exp_rsp.index_error, err);
                n_fail++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;

    srs_in_if  in_if ();
    srs_out_if out_if ();

    sensor_record_statistics_top DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    site_stats_scoreboard sb;

    // knobs shared by the sender, the receiver and the stimulus sequence
    int src_gap_pct    = 0;
    int sink_stall_pct = 0;
    bit quiet          = 1'b0;  // no idling on either side
    bit long_hold_req  = 1'b0;  // asks the receiver for one long hold

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Sender helpers. valid stays high between back-to-back transactions so
    // that no step sees two assignments to it.
    // ------------------------------------------------------------------------
    task automatic send_item(input t_item it);
        in_if.valid            <= 1'b1;
        in_if.command          <= it.command;
        in_if.site             <= it.site;
        in_if.present_mask     <= it.rec.present_mask;
        in_if.temperature      <= it.rec.temperature;
        in_if.humidity         <= it.rec.humidity;
        in_if.pressure         <= it.rec.pressure;
        in_if.battery          <= it.rec.battery;
        in_if.timestamp        <= it.rec.timestamp;
        in_if.spreading_factor <= it.rec.spreading_factor;
        in_if.stat_index       <= it.stat_index;
        do @(posedge clk); while (in_if.ready !== 1'b1);
        sb.note_transaction(it);
    endtask

    task automatic idle_src(input int n);
        in_if.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    function automatic t_item make_rec(bit s, int mask, int t, int h, int p, int b,
                                       logic [TS_W-1:0] ts, int sf);
        t_item it;
        it = '0;
        it.command              = CMD_RECORD;
        it.site                 = s;
        it.rec.present_mask     = MASK_W'(mask);
        it.rec.temperature      = TEMP_W'(t);
        it.rec.humidity         = HUM_W'(h);
        it.rec.pressure         = PRESS_W'(p);
        it.rec.battery          = BAT_W'(b);
        it.rec.timestamp        = ts;
        it.rec.spreading_factor = SF_W'(sf);
        return it;
    endfunction

    function automatic t_item make_read(bit s, t_stat_idx idx);
        t_item it;
        it = '0;
        it.command    = CMD_READ;
        it.site       = s;
        it.stat_index = idx;
        return it;
    endfunction

    // Random transaction. Values mix the full field range, the extremes and a
    // narrow band around zero so that equal-extreme cases come up; timestamps
    // are mostly small so earliest/latest ordering keeps changing.
    function automatic t_item rand_item(int read_pct);
        t_item it;
        it = '0;
        it.command = ($urandom_range(0, 99) < read_pct) ? CMD_READ : CMD_RECORD;
        it.site    = 1'($urandom_range(0, 1));
        it.rec.present_mask = ($urandom_range(0, 1) != 0) ? 5'h1f
                                                           : MASK_W'($urandom_range(0, 31));
        case ($urandom_range(0, 3))
            0:       it.rec.temperature = TEMP_W'($urandom_range(0, 32767));
            1:       it.rec.temperature = TEMP_W'(int'($urandom_range(0, 20)) - 10);
            2:       it.rec.temperature = TEMP_W'(int'($urandom_range(0, 20000)) - 10000);
            default: it.rec.temperature = ($urandom_range(0, 1) != 0) ? 15'h4000 : 15'h3fff;
        endcase
        it.rec.humidity = ($urandom_range(0, 1) != 0) ? HUM_W'($urandom_range(0, 16383))
                                                      : HUM_W'($urandom_range(0, 20));
        it.rec.pressure = ($urandom_range(0, 1) != 0) ? PRESS_W'($urandom_range(0, 262143))
                                                      : PRESS_W'($urandom_range(0, 20));
        it.rec.battery = BAT_W'($urandom_range(0, 65535));
        case ($urandom_range(0, 9))
            0:       it.rec.timestamp = '0;
            1:       it.rec.timestamp = '1;
            2, 3:    it.rec.timestamp = {$urandom, $urandom};
            default: it.rec.timestamp = TS_W'($urandom_range(1, 1000));
        endcase
        it.rec.spreading_factor = SF_W'($urandom_range(0, 15));
        // mostly valid indices, some beyond the map
        it.stat_index = ($urandom_range(0, 9) != 0) ? t_stat_idx'($urandom_range(0, 33))
                                                    : t_stat_idx'($urandom_range(34, 63));
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random ready bursts, one long hold on request, none when quiet.
    // Every branch waits at least one edge after its assignment.
    // ------------------------------------------------------------------------
    initial begin
        out_if.ready <= 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever begin
            if (long_hold_req) begin
                out_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < sink_stall_pct) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end else begin
                out_if.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
            sb.check_read(out_if.read_value, out_if.index_error);
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run when no transaction moves on either side until
    // its idle counter reaches WATCHDOG_LIMIT.
    // ------------------------------------------------------------------------
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
                (out_if.valid === 1'b1 && out_if.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------------
    initial begin
        t_item plan[$];
        int    i;
        int    k;
        int    read_pct;

        sb = new();
        rst_n                  <= 1'b0;
        in_if.valid            <= 1'b0;
        in_if.command          <= CMD_RECORD;
        in_if.site             <= 1'b0;
        in_if.present_mask     <= '0;
        in_if.temperature      <= '0;
        in_if.humidity         <= '0;
        in_if.pressure         <= '0;
        in_if.battery          <= '0;
        in_if.timestamp        <= '0;
        in_if.spreading_factor <= '0;
        in_if.stat_index       <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part -------------------------------------------------
        sink_stall_pct = 15;
        // reads straight out of reset: reset extreme, empty sf set, empty slot,
        // last index of the 6-bit range
        plan.push_back(make_read(1'b0, STAT_TEMP_MIN));
        plan.push_back(make_read(1'b0, STAT_SF_USED));
        plan.push_back(make_read(1'b0, STAT_SF_BASE));
        plan.push_back(make_read(1'b0, t_stat_idx'(63)));
        // site 0: all values missing, then field extremes, then an earlier
        // stamp for battery, then a temperature equal to the current max
        plan.push_back(make_rec(1'b0, 0, 0, 0, 0, 0, '0, 0));
        plan.push_back(make_rec(1'b0, 31, -16384, 16383, 262143, 65535, 64'd100, 15));
        plan.push_back(make_rec(1'b0, 31, 16383, 0, 0, 0, 64'd50, 0));
        plan.push_back(make_rec(1'b0, 31, 16383, 5, 5, 1234, 64'd200, 15));
        // site 1: battery with no timestamp, twice
        plan.push_back(make_rec(1'b1, 8, 0, 0, 0, 111, '0, 0));
        plan.push_back(make_rec(1'b1, 8, 0, 0, 0, 222, '0, 0));
        // site 1: eleven distinct spreading factors, the last finds the set full
        for (k = 0; k <= SF_SLOTS; k++)
            plan.push_back(make_rec(1'b1, 16, 0, 0, 0, 0, 64'd1, k));
        plan.push_back(make_read(1'b0, STAT_TEMP_MAX));
        plan.push_back(make_read(1'b0, STAT_TS_TEMP_MAX));
        plan.push_back(make_read(1'b0, STAT_BAT_FIRST_TS));
        plan.push_back(make_read(1'b1, t_stat_idx'(int'(STAT_SF_BASE) + SF_SLOTS - 1)));
        foreach (plan[j]) send_item(plan[j]);

        // --- random part ---------------------------------------------------
        read_pct = 40;
        src_gap_pct = 20;
        sink_stall_pct = 10;
        for (i = 0; i < N_RANDOM; i++) begin
            if (i == 200) begin
                // a stretch with no idling at all
                src_gap_pct = 0;
                sink_stall_pct = 0;
            end
            if (i == 350) begin
                // sender pause until every read result is back
                idle_src(1);
                while (sb.pending() != 0) @(posedge clk);
                // then read-heavy traffic against a long output hold, which
                // fills the result path and stalls the input
                src_gap_pct = 15;
                sink_stall_pct = 15;
                read_pct = 85;
                long_hold_req = 1'b1;
            end
            if (i == 420) read_pct = 40;
            if (i == N_RANDOM - QUIET_TAIL) quiet = 1'b1;
            if (!quiet && $urandom_range(0, 99) < src_gap_pct)
                idle_src($urandom_range(1, 11));
            send_item(rand_item(read_pct));
        end
        in_if.valid <= 1'b0;

        // --- drain and report ----------------------------------------------
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Ran %0d record and %0d read transactions on two sites; %0d reads hit a bad index.",
                 sb.n_records, sb.n_reads, sb.n_bad_index);
        $display("Traffic had random idling on both sides, a %0d-cycle output hold and a drain pause.",
                 LONG_HOLD);
        if (sb.n_fail == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/srs_pkg.sv
rtl/srs_if.sv
rtl/srs_site_stats.sv
rtl/sensor_record_statistics_top.sv
tb/sensor_record_statistics_top_tb.sv
